[sv/mueller_retarder_ray_chain_defines.svh]
// Assertion macros for the retarder ray chain.
`ifndef MUELLER_RETARDER_RAY_CHAIN_DEFINES_SVH
`define MUELLER_RETARDER_RAY_CHAIN_DEFINES_SVH
`ifndef SYNTH
`define MRR_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mrr: assertion failed");
`define MRR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mrr: assertion failed");
`else
`define MRR_ASSERT_IMPL(lbl, pre, post)
`define MRR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[sv/mrr_pkg.sv]
// Shared types, widths and codes of the retarder ray chain.
package mrr_pkg;

  localparam int FRAC_BITS       = 14;
  localparam int NUM_WAVELENGTHS = 3;
  localparam int NUM_WEIGHTS     = 3;
  localparam int ONE_Q           = 1 << FRAC_BITS;

  localparam int TRIG_W     = 16;
  localparam int STOKES_W   = FRAC_BITS + 4;
  localparam int COEF_W     = STOKES_W + 1;
  localparam int OPA_W      = COEF_W;
  localparam int OPB_W      = STOKES_W;
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int ACC_W      = PROD_W + 3;
  localparam int WGT_W      = 16;
  localparam int INTEN_W    = FRAC_BITS + 3;
  localparam int OUT_W      = FRAC_BITS + 1;
  localparam int WIDX_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 4 * TRIG_W;
  localparam int IN_USER_W  = WIDX_W + 1;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POL_COS2      = 3'd0,
    CFG_POL_SIN2      = 3'd1,
    CFG_ANA_COS2      = 3'd2,
    CFG_ANA_SIN2      = 3'd3,
    CFG_WEIGHT_FIRST  = 3'd4,
    CFG_WEIGHT_SECOND = 3'd5,
    CFG_WEIGHT_THIRD  = 3'd6
  } cfg_index_t;

  // Rounding position of the accumulator read-out.
  typedef enum logic [1:0] {
    RND_Q   = 2'd0,
    RND_ANA = 2'd1,
    RND_WGT = 2'd2
  } rnd_sel_t;

  typedef struct packed {
    logic     issue;
    logic     load;
    rnd_sel_t rsel;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] pol_cos2;
    logic signed [TRIG_W-1:0] pol_sin2;
    logic signed [TRIG_W-1:0] ana_cos2;
    logic signed [TRIG_W-1:0] ana_sin2;
  } cfg_regs_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

endpackage

[sv/mueller_retarder_ray_chain.sv]
// Top level: linear-retarder Mueller chain along one ray, sequenced on one shared MAC.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------
//   in_     | in        | in_tvalid/in_tready | in_tdata, in_tuser, in_tlast
//   out_    | out       | out_tvalid/out_tready| out_tdata
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each site passes its 17 products, and a last site its 20, one by one through the shared
// 19x18 multiplier and its accumulator; the product and the running sum are registered
// between operand and write-back.
// A last site waits at its final step while the result register is full and not being read.
// rst_n restores the register defaults and zeroes the Stokes state.
// The result register lets the next site be accepted while a result waits.
`include "mueller_retarder_ray_chain_defines.svh"
module mueller_retarder_ray_chain import mrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] cos_twice_azimuth, [31:16] sin_twice_azimuth,
  // [47:32] cos_retardance, [63:48] sin_retardance
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] wavelength_index, [2] first_site
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [14:0] weighted_intensity, [15] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STEP_W = 5;
  localparam int WB_LAT = 2;

  // Issue steps of the shared multiplier.
  localparam logic [STEP_W-1:0] STEP_CC    = 5'd0;
  localparam logic [STEP_W-1:0] STEP_SS    = 5'd1;
  localparam logic [STEP_W-1:0] STEP_SC    = 5'd2;
  localparam logic [STEP_W-1:0] STEP_M22   = 5'd3;
  localparam logic [STEP_W-1:0] STEP_M11   = 5'd4;
  localparam logic [STEP_W-1:0] STEP_M12   = 5'd5;
  localparam logic [STEP_W-1:0] STEP_M31   = 5'd6;
  localparam logic [STEP_W-1:0] STEP_M23   = 5'd7;
  localparam logic [STEP_W-1:0] STEP_R1A   = 5'd8;
  localparam logic [STEP_W-1:0] STEP_R1B   = 5'd9;
  localparam logic [STEP_W-1:0] STEP_R1C   = 5'd10;
  localparam logic [STEP_W-1:0] STEP_R2A   = 5'd11;
  localparam logic [STEP_W-1:0] STEP_R2B   = 5'd12;
  localparam logic [STEP_W-1:0] STEP_R2C   = 5'd13;
  localparam logic [STEP_W-1:0] STEP_R3A   = 5'd14;
  localparam logic [STEP_W-1:0] STEP_R3B   = 5'd15;
  localparam logic [STEP_W-1:0] STEP_R3C   = 5'd16;
  localparam logic [STEP_W-1:0] STEP_ANA_C = 5'd17;
  localparam logic [STEP_W-1:0] STEP_ANA_S = 5'd18;
  localparam logic [STEP_W-1:0] STEP_WGT   = 5'd21;

  // Write-back steps: the rounded sum shows after its last issue, once product and sum are registered.
  localparam logic [STEP_W-1:0] WB_CC     = STEP_CC    + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_SS     = STEP_SS    + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_SC     = STEP_SC    + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_M22    = STEP_M22   + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_M11    = STEP_M11   + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_M12    = STEP_M12   + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_M31    = STEP_M31   + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_M23    = STEP_M23   + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_N1     = STEP_R1C   + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_N2     = STEP_R2C   + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_COMMIT = STEP_R3C   + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_INTEN  = STEP_ANA_S + STEP_W'(WB_LAT);
  localparam logic [STEP_W-1:0] WB_OUT    = STEP_WGT   + STEP_W'(WB_LAT);

  localparam mac_ctrl_t MAC_LOAD_Q   = '{issue: 1'b1, load: 1'b1, rsel: RND_Q};
  localparam mac_ctrl_t MAC_LOAD_ANA = '{issue: 1'b1, load: 1'b1, rsel: RND_ANA};
  localparam mac_ctrl_t MAC_LOAD_WGT = '{issue: 1'b1, load: 1'b1, rsel: RND_WGT};
  localparam mac_ctrl_t MAC_ADD      = '{issue: 1'b1, load: 1'b0, rsel: RND_Q};

  localparam int ST_MAX    = (1 << (STOKES_W - 1)) - 1;
  localparam int ST_MIN    = -(1 << (STOKES_W - 1));
  localparam int INTEN_MAX = 4 * ONE_Q;

  function automatic logic signed [STOKES_W-1:0] sat_stokes(
    input logic signed [ACC_W-1:0] x
  );
    if (x > ACC_W'(ST_MAX)) begin
      return STOKES_W'(ST_MAX);
    end else if (x < ACC_W'(ST_MIN)) begin
      return STOKES_W'(ST_MIN);
    end
    return x[STOKES_W-1:0];
  endfunction

  function automatic logic [INTEN_W-1:0] clamp_inten(input logic signed [ACC_W-1:0] x);
    if (x < 0) begin
      return '0;
    end else if (x > ACC_W'(INTEN_MAX)) begin
      return INTEN_W'(INTEN_MAX);
    end
    return x[INTEN_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input logic signed [ACC_W-1:0] x);
    if (x < 0) begin
      return '0;
    end else if (x > ACC_W'(ONE_Q)) begin
      return OUT_W'(ONE_Q);
    end
    return x[OUT_W-1:0];
  endfunction

  // Input unpacking.
  logic signed [TRIG_W-1:0] in_cb, in_sb, in_cd, in_sd;
  logic [WIDX_W-1:0]        in_widx;
  logic                     in_first;
  logic                     in_acc;

  assign in_cb    = in_tdata[TRIG_W-1:0];
  assign in_sb    = in_tdata[2*TRIG_W-1:TRIG_W];
  assign in_cd    = in_tdata[3*TRIG_W-1:2*TRIG_W];
  assign in_sd    = in_tdata[4*TRIG_W-1:3*TRIG_W];
  assign in_widx  = in_tuser[WIDX_W-1:0];
  assign in_first = in_tuser[WIDX_W];
  assign in_acc   = in_tvalid & in_tready;

  // Sequencer and datapath state.
  state_t                     state_r, state_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       run;
  logic                       out_free, out_load, seq_done;

  logic signed [TRIG_W-1:0]   cb_r, sb_r, cd_r, sd_r;
  logic [WIDX_W-1:0]          widx_r;
  logic                       last_r;

  logic signed [STOKES_W-1:0] stokes_h_r, stokes_d_r, stokes_c_r;
  logic signed [STOKES_W-1:0] stokes_h_nxt, stokes_d_nxt, stokes_c_nxt;
  logic signed [STOKES_W-1:0] pol_h, pol_d;

  logic signed [STOKES_W-1:0] cc_r, ss_r, sc_r;
  logic signed [COEF_W-1:0]   m11_r, m12_r, m22_r;
  logic signed [STOKES_W-1:0] m13_r, m31_r, m23_r, m32_r;
  logic signed [STOKES_W-1:0] n1_r, n2_r;
  logic [INTEN_W-1:0]         inten_r;
  logic signed [TRIG_W:0]     one_minus_cd;

  logic                       out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]           out_data_r, out_data_nxt;

  cfg_regs_t                  cfg_regs;
  logic [WGT_W-1:0]           weight;

  mac_ctrl_t                  mac_ctrl;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [OPB_W-1:0]    op_b;
  logic signed [ACC_W-1:0]    mac_res;

  assign cfg_ready = 1'b1;

  mrr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .widx     (widx_r),
    .regs     (cfg_regs),
    .weight   (weight)
  );

  mrr_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .op_a  (op_a),
    .op_b  (op_b),
    .res   (mac_res)
  );

  assign out_free = !out_valid_r || out_tready;
  assign out_load = run && (step_r == WB_OUT) && out_free;
  assign seq_done = (run && (step_r == WB_COMMIT) && !last_r) || out_load;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_RUN;
      ST_RUN:  if (seq_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = 1'b0;
    run       = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_RUN:  run       = 1'b1;
      default: ;
    endcase
  end

  // Hold the final step while the result register is full and not being read.
  always_comb begin
    step_nxt = step_r;
    if (in_acc) begin
      step_nxt = '0;
    end else if (run && !((step_r == WB_OUT) && !out_free)) begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  assign one_minus_cd = (TRIG_W+1)'(ONE_Q) - (TRIG_W+1)'(cd_r);

  // Operand select and MAC control per step.
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    mac_ctrl = '0;
    if (run) begin
      unique case (step_r)
        STEP_CC: begin
          op_a = OPA_W'(cb_r); op_b = OPB_W'(cb_r); mac_ctrl = MAC_LOAD_Q;
        end
        STEP_SS: begin
          op_a = OPA_W'(sb_r); op_b = OPB_W'(sb_r); mac_ctrl = MAC_LOAD_Q;
        end
        STEP_SC: begin
          op_a = OPA_W'(sb_r); op_b = OPB_W'(cb_r); mac_ctrl = MAC_LOAD_Q;
        end
        STEP_M22: begin
          op_a = OPA_W'(cc_r); op_b = OPB_W'(cd_r); mac_ctrl = MAC_LOAD_Q;
        end
        STEP_M11: begin
          op_a = OPA_W'(ss_r); op_b = OPB_W'(cd_r); mac_ctrl = MAC_LOAD_Q;
        end
        STEP_M12: begin
          op_a = OPA_W'(sc_r); op_b = OPB_W'(one_minus_cd); mac_ctrl = MAC_LOAD_Q;
        end
        STEP_M31: begin
          op_a = OPA_W'(sb_r); op_b = OPB_W'(sd_r); mac_ctrl = MAC_LOAD_Q;
        end
        STEP_M23: begin
          op_a = OPA_W'(cb_r); op_b = OPB_W'(sd_r); mac_ctrl = MAC_LOAD_Q;
        end
        STEP_R1A: begin
          op_a = m11_r; op_b = stokes_h_r; mac_ctrl = MAC_LOAD_Q;
        end
        STEP_R1B: begin
          op_a = m12_r; op_b = stokes_d_r; mac_ctrl = MAC_ADD;
        end
        STEP_R1C: begin
          op_a = OPA_W'(m13_r); op_b = stokes_c_r; mac_ctrl = MAC_ADD;
        end
        STEP_R2A: begin
          op_a = m22_r; op_b = stokes_d_r; mac_ctrl = MAC_LOAD_Q;
        end
        STEP_R2B: begin
          op_a = m12_r; op_b = stokes_h_r; mac_ctrl = MAC_ADD;
        end
        STEP_R2C: begin
          op_a = OPA_W'(m23_r); op_b = stokes_c_r; mac_ctrl = MAC_ADD;
        end
        STEP_R3A: begin
          op_a = OPA_W'(cd_r); op_b = stokes_c_r; mac_ctrl = MAC_LOAD_Q;
        end
        STEP_R3B: begin
          op_a = OPA_W'(m31_r); op_b = stokes_h_r; mac_ctrl = MAC_ADD;
        end
        STEP_R3C: begin
          op_a = OPA_W'(m32_r); op_b = stokes_d_r; mac_ctrl = MAC_ADD;
        end
        STEP_ANA_C: begin
          op_a = OPA_W'(cfg_regs.ana_cos2); op_b = n1_r;
          if (last_r) mac_ctrl = MAC_LOAD_ANA;
        end
        STEP_ANA_S: begin
          op_a = OPA_W'(cfg_regs.ana_sin2); op_b = n2_r;
          if (last_r) mac_ctrl = MAC_ADD;
        end
        STEP_WGT: begin
          op_a = OPA_W'($signed({1'b0, inten_r}));
          op_b = OPB_W'($signed({1'b0, weight}));
          mac_ctrl = MAC_LOAD_WGT;
        end
        default: ;
      endcase
    end
  end

  // Polarizer output of an unpolarized unit beam: half of each term, rounded up.
  assign pol_h = (STOKES_W'(cfg_regs.pol_cos2) + STOKES_W'(1)) >>> 1;
  assign pol_d = (STOKES_W'(cfg_regs.pol_sin2) + STOKES_W'(1)) >>> 1;

  always_comb begin
    stokes_h_nxt = stokes_h_r;
    stokes_d_nxt = stokes_d_r;
    stokes_c_nxt = stokes_c_r;
    if (in_acc && in_first) begin
      stokes_h_nxt = pol_h;
      stokes_d_nxt = pol_d;
      stokes_c_nxt = '0;
    end else if (run && (step_r == WB_COMMIT)) begin
      stokes_h_nxt = n1_r;
      stokes_d_nxt = n2_r;
      stokes_c_nxt = sat_stokes(mac_res);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = clamp_out(mac_res);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      stokes_h_r  <= '0;
      stokes_d_r  <= '0;
      stokes_c_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      stokes_h_r  <= stokes_h_nxt;
      stokes_d_r  <= stokes_d_nxt;
      stokes_c_r  <= stokes_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      cb_r   <= in_cb;
      sb_r   <= in_sb;
      cd_r   <= in_cd;
      sd_r   <= in_sd;
      widx_r <= in_widx;
      last_r <= in_tlast;
    end
  end

  // Capture rounded MAC results into the coefficient and partial registers.
  always_ff @(posedge clk) begin
    if (run) begin
      case (step_r)
        WB_CC:  cc_r  <= mac_res[STOKES_W-1:0];
        WB_SS:  ss_r  <= mac_res[STOKES_W-1:0];
        WB_SC:  sc_r  <= mac_res[STOKES_W-1:0];
        WB_M22: m22_r <= COEF_W'(ss_r) + mac_res[COEF_W-1:0];
        WB_M11: m11_r <= COEF_W'(cc_r) + mac_res[COEF_W-1:0];
        WB_M12: m12_r <= mac_res[COEF_W-1:0];
        WB_M31: begin
          m31_r <= mac_res[STOKES_W-1:0];
          m13_r <= -mac_res[STOKES_W-1:0];
        end
        WB_M23: begin
          m23_r <= mac_res[STOKES_W-1:0];
          m32_r <= -mac_res[STOKES_W-1:0];
        end
        WB_N1:    n1_r    <= sat_stokes(mac_res);
        WB_N2:    n2_r    <= sat_stokes(mac_res);
        WB_INTEN: inten_r <= clamp_inten(mac_res);
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

  `MRR_ASSERT_IMPL(a_result_needs_last, out_load, last_r)
  `MRR_ASSERT_IMPL(a_step_in_schedule, state_r == ST_RUN, step_r <= WB_OUT)
  `MRR_ASSERT_NEXT(a_linear_hold, run && (step_r != WB_COMMIT), $stable({stokes_h_r, stokes_d_r}))
  `MRR_ASSERT_NEXT(a_circular_hold, run && (step_r != WB_COMMIT), $stable(stokes_c_r))
  `MRR_ASSERT_IMPL(a_result_range, out_valid_r, out_data_r <= OUT_W'(ONE_Q))

endmodule

[sv/mrr_cfg.sv]
// Configuration register file: polarizer, analyzer and wavelength weights.
module mrr_cfg import mrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic [WIDX_W-1:0]     widx,
  output cfg_regs_t             regs,
  output logic [WGT_W-1:0]      weight
);

  cfg_regs_t        regs_r, regs_nxt;
  logic [WGT_W-1:0] weight_r   [NUM_WEIGHTS];
  logic [WGT_W-1:0] weight_nxt [NUM_WEIGHTS];

  always_comb begin
    regs_nxt   = regs_r;
    weight_nxt = weight_r;
    if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        CFG_POL_COS2:      regs_nxt.pol_cos2 = wr_data;
        CFG_POL_SIN2:      regs_nxt.pol_sin2 = wr_data;
        CFG_ANA_COS2:      regs_nxt.ana_cos2 = wr_data;
        CFG_ANA_SIN2:      regs_nxt.ana_sin2 = wr_data;
        CFG_WEIGHT_FIRST:  weight_nxt[0]     = wr_data;
        CFG_WEIGHT_SECOND: weight_nxt[1]     = wr_data;
        CFG_WEIGHT_THIRD:  weight_nxt[2]     = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.pol_cos2 <= 16'sd16384;
      regs_r.pol_sin2 <= 16'sd0;
      regs_r.ana_cos2 <= -16'sd16384;
      regs_r.ana_sin2 <= 16'sd0;
      weight_r[0]     <= 16'd13107;
      weight_r[1]     <= 16'd26214;
      weight_r[2]     <= 16'd13107;
    end else begin
      regs_r   <= regs_nxt;
      weight_r <= weight_nxt;
    end
  end

  // Unused wavelength codes select a zero weight.
  always_comb begin
    weight = '0;
    if ((widx < NUM_WAVELENGTHS) && (widx < NUM_WEIGHTS)) begin
      weight = weight_r[widx];
    end
  end

  assign regs = regs_r;

endmodule

[sv/mrr_mac.sv]
// Shared multiply-accumulate unit with a registered product and rounding read-out.
module mrr_mac import mrr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctrl_t               ctrl,
  input  logic signed [OPA_W-1:0] op_a,
  input  logic signed [OPB_W-1:0] op_b,
  output logic signed [ACC_W-1:0] res
);

  localparam logic signed [ACC_W-1:0] BIAS_Q   = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] BIAS_ANA =
    ACC_W'((64'sd1 <<< (2 * FRAC_BITS - 1)) + (64'sd1 <<< FRAC_BITS));
  localparam logic signed [ACC_W-1:0] BIAS_WGT = ACC_W'(64'sd1 <<< (WGT_W - 1));

  mac_ctrl_t                 ctrl_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   bias;
  rnd_sel_t                  rsel_r, rsel_nxt;

  assign prod_nxt = op_a * op_b;

  // Load starts a new sum with its rounding offset preset; otherwise the product adds to the running sum.
  always_comb begin
    case (ctrl_r.rsel)
      RND_ANA: bias = BIAS_ANA;
      RND_WGT: bias = BIAS_WGT;
      default: bias = BIAS_Q;
    endcase
    acc_nxt  = (ctrl_r.load ? bias : acc_r) + ACC_W'(prod_r);
    rsel_nxt = ctrl_r.load ? ctrl_r.rsel : rsel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctrl_r.issue) begin
      acc_r  <= acc_nxt;
      rsel_r <= rsel_nxt;
    end
  end

  always_comb begin
    case (rsel_r)
      RND_ANA: res = acc_r >>> (FRAC_BITS + 1);
      RND_WGT: res = acc_r >>> WGT_W;
      default: res = acc_r >>> FRAC_BITS;
    endcase
  end

endmodule

[bench/mueller_retarder_ray_chain_tb.sv]
// Self-checking testbench for the retarder ray chain: rays in, weighted intensities checked.
`timescale 1ns / 100ps

module mueller_retarder_ray_chain_tb;
  import mrr_pkg::*;

  localparam int          CYCLE_LIMIT   = 600000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          MAX_REPORTS   = 10;
  localparam int          N_DIRECTED    = 19;
  localparam longint      ONE_L         = longint'(1) <<< FRAC_BITS;
  localparam longint      HALF_L        = longint'(1) <<< (FRAC_BITS - 1);

  localparam logic [TRIG_W-1:0] T_ZERO  = 16'h0000;
  localparam logic [TRIG_W-1:0] Q_ONE   = 16'h4000;
  localparam logic [TRIG_W-1:0] Q_NEG   = 16'hC000;
  localparam logic [TRIG_W-1:0] T_MAX   = 16'h7FFF;
  localparam logic [TRIG_W-1:0] T_MIN   = 16'h8000;
  localparam logic [TRIG_W-1:0] R_HALF  = 16'h2D41;  // cos 45 deg
  localparam logic [TRIG_W-1:0] R_NHALF = 16'hD2BF;

  typedef struct packed {
    logic [TRIG_W-1:0] cos_az;
    logic [TRIG_W-1:0] sin_az;
    logic [TRIG_W-1:0] cos_ret;
    logic [TRIG_W-1:0] sin_ret;
    logic [WIDX_W-1:0] wl_index;
    logic              first_site;
    logic              last_site;
    logic              typed;   // want holds the expected intensity
    logic [OUT_W-1:0]  want;
  } site_t;

  // cos_az, sin_az, cos_ret, sin_ret, wl_index, first, last, typed, want
  localparam site_t DIRECTED_SITES [N_DIRECTED] = '{
    '{Q_ONE,  T_ZERO, Q_ONE,  T_ZERO, 2'd0, 1'b0, 1'b1, 1'b1, 15'd819},  // ray with no first
    '{Q_ONE,  T_ZERO, Q_ONE,  T_ZERO, 2'd0, 1'b1, 1'b1, 1'b1, 15'd0},    // crossed, no plate
    '{T_ZERO, Q_ONE,  Q_NEG,  T_ZERO, 2'd0, 1'b1, 1'b1, 1'b1, 15'd1638}, // half wave at 45
    '{T_ZERO, Q_ONE,  Q_NEG,  T_ZERO, 2'd1, 1'b1, 1'b1, 1'b1, 15'd3277},
    '{T_ZERO, Q_ONE,  Q_NEG,  T_ZERO, 2'd2, 1'b1, 1'b1, 1'b1, 15'd1638},
    '{T_ZERO, Q_ONE,  Q_NEG,  T_ZERO, 2'd3, 1'b1, 1'b1, 1'b1, 15'd0},    // no such wavelength
    '{R_HALF, R_HALF, T_ZERO, Q_ONE,  2'd1, 1'b1, 1'b1, 1'b0, 15'd0},
    '{T_ZERO, Q_ONE,  T_ZERO, Q_ONE,  2'd1, 1'b1, 1'b0, 1'b0, 15'd0},
    '{R_HALF, R_NHALF,T_ZERO, Q_NEG,  2'd1, 1'b0, 1'b0, 1'b0, 15'd0},
    '{Q_NEG,  T_ZERO, T_ZERO, Q_ONE,  2'd2, 1'b0, 1'b1, 1'b0, 15'd0},
    '{T_MAX,  T_ZERO, T_MAX,  T_ZERO, 2'd0, 1'b1, 1'b0, 1'b0, 15'd0},    // drive into saturation
    '{T_MAX,  T_ZERO, T_MAX,  T_ZERO, 2'd0, 1'b0, 1'b0, 1'b0, 15'd0},
    '{T_MAX,  T_MAX,  T_MAX,  T_MAX,  2'd0, 1'b0, 1'b1, 1'b0, 15'd0},
    '{T_MIN,  T_MIN,  T_MIN,  T_MIN,  2'd1, 1'b1, 1'b1, 1'b0, 15'd0},
    '{T_MIN,  T_MAX,  T_MAX,  T_MIN,  2'd3, 1'b1, 1'b1, 1'b1, 15'd0},
    '{T_ZERO, T_ZERO, T_ZERO, T_ZERO, 2'd2, 1'b1, 1'b1, 1'b1, 15'd819},  // null matrix
    '{Q_ONE,  T_ZERO, Q_NEG,  T_ZERO, 2'd0, 1'b1, 1'b0, 1'b0, 15'd0},    // abandoned ray
    '{T_ZERO, Q_ONE,  Q_NEG,  T_ZERO, 2'd1, 1'b1, 1'b1, 1'b1, 15'd3277},
    '{Q_NEG,  T_ZERO, Q_ONE,  T_ZERO, 2'd0, 1'b0, 1'b1, 1'b0, 15'd0}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [IN_USER_W-1:0]  in_tuser  = '0;
  logic                  in_tlast  = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index = CFG_POL_COS2;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic rx_hold = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  // Shadow of the block: settings and running Stokes vector.
  logic signed [TRIG_W-1:0]   pol_cos2_q = 16'sd16384;
  logic signed [TRIG_W-1:0]   pol_sin2_q = 16'sd0;
  logic signed [TRIG_W-1:0]   ana_cos2_q = -16'sd16384;
  logic signed [TRIG_W-1:0]   ana_sin2_q = 16'sd0;
  logic [WGT_W-1:0]           weight_q [NUM_WEIGHTS] = '{16'd13107, 16'd26214, 16'd13107};
  logic signed [STOKES_W-1:0] stokes_h = '0;
  logic signed [STOKES_W-1:0] stokes_d = '0;
  logic signed [STOKES_W-1:0] stokes_c = '0;

  logic [OUT_DATA_W-1:0] intensity_due [$];

  mueller_retarder_ray_chain u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Round half up: floor((x + 2^(n-1)) / 2^n).
  function automatic longint round_shift(input longint x, input int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint mul_q(input longint a, input longint b);
    return round_shift(a * b, FRAC_BITS);
  endfunction

  function automatic logic signed [STOKES_W-1:0] clamp_stokes(input longint x);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (STOKES_W - 1)) - 1;
    lo = -(longint'(1) <<< (STOKES_W - 1));
    if (x > hi) x = hi;
    if (x < lo) x = lo;
    return STOKES_W'(x);
  endfunction

  // Push one site through the Stokes chain; true when it ends a ray.
  function automatic logic advance_ray(input site_t s, output logic [OUT_W-1:0] due);
    longint cb, sb, cd, sd, s1, s2, s3;
    longint cc, ss, sc, m11, m12, m13, m22, m23, m31, m32, m33;
    longint acc, inten, wgt, res;
    cb = longint'($signed(s.cos_az));
    sb = longint'($signed(s.sin_az));
    cd = longint'($signed(s.cos_ret));
    sd = longint'($signed(s.sin_ret));
    due = '0;
    if (s.first_site) begin
      stokes_h = clamp_stokes(mul_q(HALF_L, longint'(pol_cos2_q)));
      stokes_d = clamp_stokes(mul_q(HALF_L, longint'(pol_sin2_q)));
      stokes_c = '0;
    end
    s1 = longint'(stokes_h);
    s2 = longint'(stokes_d);
    s3 = longint'(stokes_c);
    cc  = mul_q(cb, cb);
    ss  = mul_q(sb, sb);
    sc  = mul_q(sb, cb);
    m11 = cc + mul_q(ss, cd);
    m12 = mul_q(sc, ONE_L - cd);
    m13 = -mul_q(sb, sd);
    m22 = ss + mul_q(cc, cd);
    m23 = mul_q(cb, sd);
    m31 = mul_q(sb, sd);
    m32 = -mul_q(cb, sd);
    m33 = cd;
    stokes_h = clamp_stokes(round_shift(m11 * s1 + m12 * s2 + m13 * s3, FRAC_BITS));
    stokes_d = clamp_stokes(round_shift(m12 * s1 + m22 * s2 + m23 * s3, FRAC_BITS));
    stokes_c = clamp_stokes(round_shift(m31 * s1 + m32 * s2 + m33 * s3, FRAC_BITS));
    if (!s.last_site) return 1'b0;
    acc = HALF_L * ONE_L + longint'(ana_cos2_q) * longint'(stokes_h)
          + longint'(ana_sin2_q) * longint'(stokes_d);
    inten = round_shift(acc, FRAC_BITS + 1);
    wgt = 0;
    if (s.wl_index < NUM_WEIGHTS && s.wl_index < NUM_WAVELENGTHS)
      wgt = longint'(weight_q[s.wl_index]);
    if (inten < 0) inten = 0;
    if (inten > 4 * ONE_L) inten = 4 * ONE_L;
    res = round_shift(inten * wgt, 16);
    if (res < 0) res = 0;
    if (res > ONE_L) res = ONE_L;
    due = OUT_W'(res);
    return 1'b1;
  endfunction

  function automatic logic [TRIG_W-1:0] random_trig();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) return TRIG_W'($urandom_range(32768) - 16384);
    if (pick < 85) begin
      case ($urandom_range(4))
        0: return T_MAX;
        1: return T_MIN;
        2: return Q_ONE;
        3: return Q_NEG;
        default: return T_ZERO;
      endcase
    end
    return TRIG_W'($urandom);
  endfunction

  function automatic site_t random_site();
    site_t s;
    s.cos_az     = random_trig();
    s.sin_az     = random_trig();
    s.cos_ret    = random_trig();
    s.sin_ret    = random_trig();
    s.wl_index   = ($urandom_range(9) == 0) ? WIDX_W'(3) : WIDX_W'($urandom_range(2));
    s.first_site = 1'b0;
    s.last_site  = 1'b0;
    s.typed      = 1'b0;
    s.want       = '0;
    return s;
  endfunction

  // Offer one beat, hold it until taken, then log what it should produce.
  task automatic send_site(input site_t s);
    logic [OUT_W-1:0] due;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.sin_ret, s.cos_ret, s.sin_az, s.cos_az};
    in_tuser  <= {s.first_site, s.wl_index};
    in_tlast  <= s.last_site;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (advance_ray(s, due))
      intensity_due.push_back(OUT_DATA_W'(s.typed ? s.want : due));
  endtask

  // Mostly whole rays; some stray beats, rays without a start, rays cut short.
  task automatic send_random_items(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned shape;
    site_t s;
    sent = 0;
    while (sent < count) begin
      shape = $urandom_range(99);
      if (shape < 8) begin
        s = random_site();
        s.first_site = 1'($urandom);
        s.last_site  = 1'($urandom);
        send_site(s);
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(5, 1);
        for (int k = 0; k < len; k++) begin
          s = random_site();
          s.first_site = (k == 0) && !(shape < 12);
          s.last_site  = (k == len - 1) && !(shape >= 12 && shape < 15);
          send_site(s);
          sent++;
        end
      end
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_POL_COS2:      pol_cos2_q = value;
      CFG_POL_SIN2:      pol_sin2_q = value;
      CFG_ANA_COS2:      ana_cos2_q = value;
      CFG_ANA_SIN2:      ana_sin2_q = value;
      CFG_WEIGHT_FIRST:  weight_q[0] = value;
      CFG_WEIGHT_SECOND: weight_q[1] = value;
      CFG_WEIGHT_THIRD:  weight_q[2] = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] pc, ps, ac, as_val,
                               input logic [CFG_DATA_W-1:0] w0, w1, w2);
    write_reg(CFG_POL_COS2, pc);
    write_reg(CFG_POL_SIN2, ps);
    write_reg(CFG_ANA_COS2, ac);
    write_reg(CFG_ANA_SIN2, as_val);
    write_reg(CFG_WEIGHT_FIRST, w0);
    write_reg(CFG_WEIGHT_SECOND, w1);
    write_reg(CFG_WEIGHT_THIRD, w2);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, let every result drain, then give a site still in flight time to finish.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (intensity_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (intensity_due.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected intensity beat %0d at cycle %0d", out_tdata, cycle_count);
          mismatches++;
        end else if (out_tdata !== intensity_due[0]) begin
          if (mismatches < MAX_REPORTS)
            $display("intensity mismatch at cycle %0d: expected %0d, got %0d",
                     cycle_count, intensity_due[0], out_tdata);
          mismatches++;
          void'(intensity_due.pop_front());
        end else begin
          void'(intensity_due.pop_front());
        end
      end
      out_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 13;
    recv_idle_pct = 65;
    foreach (DIRECTED_SITES[i]) send_site(DIRECTED_SITES[i]);
    wait_drained();

    load_settings(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random_items(400);
    wait_drained();

    send_idle_pct = 65;
    recv_idle_pct = 13;
    load_settings(Q_NEG, Q_NEG, Q_NEG, Q_NEG, 16'h0000, 16'h0001, 16'h8000);
    send_random_items(400);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    send_random_items(400);
    wait_drained();

    load_settings(16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
                  16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)));
    // Stall the output long enough to back up the result register and the input.
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_random_items(400);
    wait_drained();

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/mrr_pkg.sv
sv/mrr_cfg.sv
sv/mrr_mac.sv
sv/mueller_retarder_ray_chain.sv
bench/mueller_retarder_ray_chain_tb.sv
